// File: rtl/plwa_pkg.sv
package plwa_pkg;

  localparam int VALUE_W = 32;
  localparam int POS_W   = 16;
  localparam int COUNT_W = 7;
  localparam int MEAN_W  = 48;
  localparam int FRAC_W  = 16;

  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_DELETE  = 2'd1;
  localparam logic [1:0] OP_AVERAGE = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_EMPTY   = 2'd3;

  typedef struct packed {
    logic [1:0]                op;
    logic signed [VALUE_W-1:0] value;
    logic signed [POS_W-1:0]   position;
  } in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic [COUNT_W-1:0]       entry_count;
    logic signed [MEAN_W-1:0] mean_q16;
  } out_t;

endpackage

// File: rtl/plwa_ram.sv
module plwa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/positional_list_with_average.sv
// Channel  Ports                           Transfer
// -------  ------------------------------  -----------------------------------
// input    in_valid  in_ready  in_data     one insert, delete or average item
// output   out_valid out_ready out_data    one result per input item
//
// One item is in flight at a time; in_ready is high only while the sequencer idles.
// Insert and delete move one entry per cycle through the single-port-write RAM.
// Average runs a restoring divider, one quotient bit per cycle.
// Reset (rst_n low, synchronous) empties the list; the RAM itself is not cleared.
// A result waiting on out_ready holds the next item in its finish step, and in_ready low.
module positional_list_with_average #(
  parameter int CAPACITY = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  plwa_pkg::in_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output plwa_pkg::out_t out_data
);

  import plwa_pkg::*;

  localparam int AW    = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = VALUE_W + AW;
  localparam int DIV_W = SUM_W + FRAC_W;
  localparam int STP_W = $clog2(DIV_W + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_INS  = 3'd1;
  localparam logic [2:0] S_DEL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]               state_r, state_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic signed [SUM_W-1:0]  sum_r, sum_nxt;
  logic [CNT_W-1:0]         idx_r, idx_nxt;
  logic [CNT_W-1:0]         slot_r, slot_nxt;
  logic [AW-1:0]            wa_r, wa_nxt;
  logic                     pend_r, pend_nxt;
  logic                     kill_r, kill_nxt;
  logic                     first_r, first_nxt;
  logic [VALUE_W-1:0]       val_r, val_nxt;
  logic [1:0]               status_r, status_nxt;
  logic [DIV_W-1:0]         q_r, q_nxt;
  logic [CNT_W-1:0]         rem_r, rem_nxt;
  logic                     neg_r, neg_nxt;
  logic [STP_W-1:0]         step_r, step_nxt;
  logic                     out_valid_r, out_valid_nxt;
  out_t                     out_data_r, out_data_nxt;

  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [VALUE_W-1:0]       ram_wdata;
  logic [AW-1:0]            ram_raddr;
  logic [VALUE_W-1:0]       ram_rdata;

  logic [CNT_W-1:0]         idx_m1;
  logic [POS_W-1:0]         pos_u;
  logic [POS_W-1:0]         count_ext;
  logic                     pos_ge1;
  logic [SUM_W-1:0]         sum_mag;
  logic [CNT_W:0]           trial;
  logic                     trial_ge;
  logic [DIV_W-1:0]         q_signed;

  plwa_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign idx_m1    = idx_r - CNT_W'(1);
  assign pos_u     = {1'b0, in_data.position[POS_W-2:0]};
  assign count_ext = POS_W'(count_r);
  assign pos_ge1   = !in_data.position[POS_W-1] && (in_data.position != '0);
  assign sum_mag   = sum_r[SUM_W-1] ? SUM_W'(-sum_r) : SUM_W'(sum_r);
  assign trial     = {rem_r, q_r[DIV_W-1]};
  assign trial_ge  = trial >= {1'b0, count_r};
  assign q_signed  = neg_r ? (~q_r + DIV_W'(1)) : q_r;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    idx_nxt       = idx_r;
    slot_nxt      = slot_r;
    wa_nxt        = wa_r;
    pend_nxt      = pend_r;
    kill_nxt      = kill_r;
    first_nxt     = first_r;
    val_nxt       = val_r;
    status_nxt    = status_r;
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    neg_nxt       = neg_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = wa_r;
    ram_wdata     = ram_rdata;
    ram_raddr     = idx_r[AW-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          val_nxt    = in_data.value;
          q_nxt      = '0;
          neg_nxt    = 1'b0;
          pend_nxt   = 1'b0;
          first_nxt  = 1'b1;
          status_nxt = ST_DONE;
          state_nxt  = S_FIN;
          unique case (in_data.op)
            OP_INSERT: begin
              if (!pos_ge1) begin
                status_nxt = ST_IGNORED;
              end else if (count_r >= CNT_W'(CAPACITY)) begin
                status_nxt = ST_FULL;
              end else begin
                // Past the end of the list the value is appended.
                slot_nxt  = (pos_u > count_ext + POS_W'(1)) ? count_r
                                                           : CNT_W'(pos_u - POS_W'(1));
                idx_nxt   = count_r;
                state_nxt = S_INS;
              end
            end
            OP_DELETE: begin
              if (!pos_ge1 || pos_u > count_ext) begin
                status_nxt = ST_IGNORED;
              end else begin
                slot_nxt  = CNT_W'(pos_u - POS_W'(1));
                idx_nxt   = CNT_W'(pos_u - POS_W'(1));
                state_nxt = S_DEL;
              end
            end
            OP_AVERAGE: begin
              if (count_r == '0) begin
                status_nxt = ST_EMPTY;
              end else begin
                q_nxt     = {sum_mag, {FRAC_W{1'b0}}};
                neg_nxt   = sum_r[SUM_W-1];
                rem_nxt   = '0;
                step_nxt  = '0;
                state_nxt = S_DIV;
              end
            end
            default: begin
              status_nxt = ST_IGNORED;
            end
          endcase
        end
      end

      // Shift entries up from the tail, one read and one write per cycle.
      S_INS: begin
        ram_raddr = idx_m1[AW-1:0];
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = wa_r;
          ram_wdata = ram_rdata;
        end else if (idx_r == slot_r) begin
          ram_we    = 1'b1;
          ram_waddr = slot_r[AW-1:0];
          ram_wdata = val_r;
        end
        if (idx_r != slot_r) begin
          pend_nxt = 1'b1;
          wa_nxt   = idx_r[AW-1:0];
          idx_nxt  = idx_m1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            count_nxt = count_r + CNT_W'(1);
            sum_nxt   = sum_r + {{(SUM_W-VALUE_W){val_r[VALUE_W-1]}}, val_r};
            state_nxt = S_FIN;
          end
        end
      end

      // The first word read back is the removed entry; later ones move down.
      S_DEL: begin
        ram_raddr = idx_r[AW-1:0];
        if (pend_r && !kill_r) begin
          ram_we    = 1'b1;
          ram_waddr = wa_r;
          ram_wdata = ram_rdata;
        end
        if (pend_r && kill_r) begin
          sum_nxt = sum_r - {{(SUM_W-VALUE_W){ram_rdata[VALUE_W-1]}}, ram_rdata};
        end
        if (idx_r < count_r) begin
          pend_nxt  = 1'b1;
          kill_nxt  = first_r;
          first_nxt = 1'b0;
          wa_nxt    = idx_m1[AW-1:0];
          idx_nxt   = idx_r + CNT_W'(1);
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            count_nxt = count_r - CNT_W'(1);
            state_nxt = S_FIN;
          end
        end
      end

      // Restoring division of the magnitude, one quotient bit per cycle.
      S_DIV: begin
        rem_nxt  = trial_ge ? CNT_W'(trial - {1'b0, count_r}) : CNT_W'(trial);
        q_nxt    = {q_r[DIV_W-2:0], trial_ge};
        step_nxt = step_r + STP_W'(1);
        if (step_r == STP_W'(DIV_W - 1)) begin
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.status      = status_r;
          out_data_nxt.entry_count = COUNT_W'(count_r);
          out_data_nxt.mean_q16    = q_signed[MEAN_W-1:0];
          state_nxt                = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      sum_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    slot_r     <= slot_nxt;
    wa_r       <= wa_nxt;
    kill_r     <= kill_nxt;
    first_r    <= first_nxt;
    val_r      <= val_nxt;
    status_r   <= status_nxt;
    q_r        <= q_nxt;
    rem_r      <= rem_nxt;
    neg_r      <= neg_nxt;
    step_r     <= step_nxt;
    out_data_r <= out_data_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && status_r == ST_FULL) |-> count_r == CNT_W'(CAPACITY))
    else $error("store-full status with free entries");

  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_DIV || state_r == S_FIN) |-> !ram_we)
    else $error("RAM written outside a shift");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> rem_r < count_r)
    else $error("divider remainder not below divisor");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second transaction accepted while busy");

endmodule

// File: bench/positional_list_with_average_checker.sv
`timescale 1ns / 1ps

module positional_list_with_average_checker #(
  parameter int CAPACITY = 64
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_ready,
  input  plwa_pkg::in_t  in_data,
  input  logic           out_valid,
  input  logic           out_ready,
  input  plwa_pkg::out_t out_data,
  output int             errors,
  output int             pending,
  output int             list_len,
  output int             peak_len,
  output int             n_done,
  output int             n_ignored,
  output int             n_full,
  output int             n_empty
);

  import plwa_pkg::*;

  // Shadow copy of the list, kept in step with every accepted input transaction.
  logic signed [VALUE_W-1:0] shadow_list [CAPACITY];
  int                        shadow_len;
  longint                    shadow_sum;
  out_t                      results_due [$];
  int                        results_seen;

  function automatic out_t list_outcome(in_t item);
    out_t   r;
    int     pos;
    int     slot;
    int     i;
    longint mag;
    longint q;
    logic   neg;
    r   = '0;
    pos = $signed(item.position);
    case (item.op)
      OP_INSERT: begin
        if (pos < 1) begin
          r.status = ST_IGNORED;
        end else if (shadow_len >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          // Positions past the tail append.
          slot = (pos > shadow_len + 1) ? shadow_len : pos - 1;
          for (i = shadow_len; i > slot; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[slot] = item.value;
          shadow_len++;
          shadow_sum += $signed(item.value);
          r.status = ST_DONE;
        end
      end
      OP_DELETE: begin
        if (pos < 1 || pos > shadow_len) begin
          r.status = ST_IGNORED;
        end else begin
          slot = pos - 1;
          shadow_sum -= shadow_list[slot];
          for (i = slot; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
          shadow_len--;
          r.status = ST_DONE;
        end
      end
      OP_AVERAGE: begin
        if (shadow_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // Divide the magnitude so the quotient truncates toward zero.
          neg = shadow_sum < 0;
          mag = neg ? -shadow_sum : shadow_sum;
          q   = (mag <<< FRAC_W) / shadow_len;
          if (neg) q = -q;
          r.mean_q16 = q[MEAN_W-1:0];
          r.status   = ST_DONE;
        end
      end
      default: r.status = ST_IGNORED;
    endcase
    r.entry_count = shadow_len[COUNT_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    out_t want;
    int   bad;
    bad = 0;
    if (!rst_n) begin
      shadow_len   = 0;
      shadow_sum   = 0;
      results_seen = 0;
      results_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (results_due.size() == 0) begin
          $display("%0t: result %0d arrived with no transaction outstanding (got %h)",
                   $time, results_seen, out_data);
          bad++;
        end else begin
          want = results_due.pop_front();
          if (out_data.status !== want.status) begin
            $display("%0t: result %0d status expected %0d, got %0d",
                     $time, results_seen, want.status, out_data.status);
            bad++;
          end
          if (out_data.entry_count !== want.entry_count) begin
            $display("%0t: result %0d entry_count expected %0d, got %0d",
                     $time, results_seen, want.entry_count, out_data.entry_count);
            bad++;
          end
          if (out_data.mean_q16 !== want.mean_q16) begin
            $display("%0t: result %0d mean_q16 expected %0d, got %0d",
                     $time, results_seen, want.mean_q16, out_data.mean_q16);
            bad++;
          end
          case (want.status)
            ST_DONE:    n_done    <= n_done + 1;
            ST_IGNORED: n_ignored <= n_ignored + 1;
            ST_FULL:    n_full    <= n_full + 1;
            default:    n_empty   <= n_empty + 1;
          endcase
        end
      end
      if (in_valid && in_ready) results_due.push_back(list_outcome(in_data));
      errors   <= errors + bad;
      pending  <= results_due.size();
      list_len <= shadow_len;
      if (shadow_len > peak_len) peak_len <= shadow_len;
    end
  end

endmodule

// File: bench/positional_list_with_average_tb.sv
`timescale 1ns / 1ps

module positional_list_with_average_tb;
  import plwa_pkg::*;

  localparam int         CAPACITY  = 64;
  localparam int         ITEMS     = 1750;
  localparam int         LIMIT     = 1000000;
  localparam int         HOLD_LONG = 400;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int MODE_FILL     = 0;
  localparam int MODE_DRAIN    = 1;
  localparam int MODE_BALANCED = 2;

  localparam int VALS_MIXED = 0;
  localparam int VALS_MAX   = 1;
  localparam int VALS_MIN   = 2;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  int errors;
  int pending;
  int list_len;
  int peak_len;
  int n_done;
  int n_ignored;
  int n_full;
  int n_empty;
  int cycles = 0;
  int holdoffs = 0;
  int drains = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  positional_list_with_average #(.CAPACITY(CAPACITY)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  positional_list_with_average_checker #(.CAPACITY(CAPACITY)) list_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .errors    (errors),
    .pending   (pending),
    .list_len  (list_len),
    .peak_len  (peak_len),
    .n_done    (n_done),
    .n_ignored (n_ignored),
    .n_full    (n_full),
    .n_empty   (n_empty)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.", cycles, pending);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic in_t make_item(logic [1:0] op, logic [31:0] value, logic [15:0] position);
    in_t item;
    item.op       = op;
    item.value    = value;
    item.position = position;
    return item;
  endfunction

  function automatic logic [1:0] draw_op(int mode);
    int r;
    r = $urandom_range(99, 0);
    case (mode)
      MODE_FILL:  return (r < 85) ? OP_INSERT : (r < 90) ? OP_DELETE :
                         (r < 98) ? OP_AVERAGE : OP_UNUSED;
      MODE_DRAIN: return (r < 10) ? OP_INSERT : (r < 85) ? OP_DELETE :
                         (r < 98) ? OP_AVERAGE : OP_UNUSED;
      default:    return (r < 40) ? OP_INSERT : (r < 80) ? OP_DELETE :
                         (r < 97) ? OP_AVERAGE : OP_UNUSED;
    endcase
  endfunction

  function automatic logic [31:0] draw_value(int style);
    case (style)
      VALS_MAX: return 32'h7FFF_FFFF;
      VALS_MIN: return 32'h8000_0000;
      default: begin
        case ($urandom_range(7, 0))
          0:       return 32'h7FFF_FFFF;
          1:       return 32'h8000_0000;
          2, 3:    return 32'($urandom_range(200, 0)) - 32'd100;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  // Mostly positions inside the list, with some at the boundaries and some anywhere.
  function automatic logic [15:0] draw_position(logic [1:0] op, int len);
    int sel;
    sel = $urandom_range(9, 0);
    if (sel == 0) return 16'($urandom);
    if (sel == 1) begin
      case ($urandom_range(6, 0))
        0:       return 16'd0;
        1:       return 16'hFFFF;
        2:       return 16'(len);
        3:       return 16'(len + 1);
        4:       return 16'(len + 2);
        5:       return 16'h7FFF;
        default: return 16'h8000;
      endcase
    end
    if (op == OP_DELETE) return 16'($urandom_range((len > 0) ? len : 1, 1));
    return 16'($urandom_range(len + 1, 1));
  endfunction

  // Called at a rising edge; returns at the edge where the transaction is taken.
  task automatic send_item(in_t item, int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_outstanding();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Result side: random stalls, calm stretches, and two long hold-offs.
  initial begin
    int taken;
    int hold;
    bit calm;
    taken = 0;
    calm  = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (taken == 300 || taken == 1200) begin
        hold = HOLD_LONG;
        holdoffs++;
      end else begin
        hold = calm ? 0 : $urandom_range(16, 0);
      end
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      taken++;
      if ($urandom_range(39, 0) == 0) calm = !calm;
    end
  end

  initial begin
    int   bursts;
    int   burst_len;
    int   mode;
    int   style;
    int   gap_max;
    logic [1:0] op;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty list, rejected positions, front, middle and tail edits, extremes.
    send_item(make_item(OP_AVERAGE, 32'd0, 16'd1), 0);
    send_item(make_item(OP_DELETE, 32'd0, 16'd1), $urandom_range(16, 0));
    send_item(make_item(OP_INSERT, 32'd9, 16'd0), $urandom_range(16, 0));
    send_item(make_item(OP_INSERT, 32'd9, 16'h8000), 0);
    send_item(make_item(OP_INSERT, 32'h7FFF_FFFF, 16'd1), $urandom_range(16, 0));
    send_item(make_item(OP_INSERT, 32'h8000_0000, 16'h7FFF), 0);
    send_item(make_item(OP_INSERT, 32'hFFFF_FFFF, 16'd1), $urandom_range(16, 0));
    send_item(make_item(OP_INSERT, 32'd5, 16'd2), 0);
    send_item(make_item(OP_AVERAGE, 32'hFFFF_FFFF, 16'hFFFF), $urandom_range(16, 0));
    send_item(make_item(OP_DELETE, 32'd0, 16'd5), 0);
    send_item(make_item(OP_DELETE, 32'd0, 16'd0), 0);
    send_item(make_item(OP_DELETE, 32'd0, 16'hFFFF), $urandom_range(16, 0));
    send_item(make_item(OP_DELETE, 32'd0, 16'd4), 0);
    send_item(make_item(OP_DELETE, 32'd0, 16'd1), $urandom_range(16, 0));
    send_item(make_item(OP_INSERT, 32'hFFFF_FFF9, 16'd2), 0);
    send_item(make_item(OP_INSERT, 32'd3, 16'd4), $urandom_range(16, 0));
    send_item(make_item(OP_AVERAGE, 32'd0, 16'd0), 0);
    send_item(make_item(OP_UNUSED, 32'hFFFF_FFFF, 16'hFFFF), $urandom_range(16, 0));
    send_item(make_item(OP_DELETE, 32'd0, 16'h7FFF), 0);
    send_item(make_item(OP_DELETE, 32'd0, 16'd2), 0);
    send_item(make_item(OP_AVERAGE, 32'd0, 16'd1), $urandom_range(16, 0));
    drain_outstanding();
    drains++;

    // Random bursts that push the list toward full, toward empty, or keep it level.
    bursts = 0;
    while (n_done + n_ignored + n_full + n_empty < ITEMS) begin
      mode      = $urandom_range(2, 0);
      burst_len = (mode == MODE_FILL) ? $urandom_range(100, 60) : $urandom_range(80, 20);
      case ($urandom_range(5, 0))
        0:       style = VALS_MAX;
        1:       style = VALS_MIN;
        default: style = VALS_MIXED;
      endcase
      gap_max = ($urandom_range(2, 0) == 0) ? 0 : 16;
      repeat (burst_len) begin
        op = draw_op(mode);
        send_item(make_item(op, draw_value(style), draw_position(op, list_len)),
                  $urandom_range(gap_max, 0));
      end
      bursts++;
      if (bursts % 6 == 0) begin
        drain_outstanding();
        drains++;
      end
    end

    drain_outstanding();
    repeat (150) @(posedge clk);
    $display("Covered %0d results: %0d completed, %0d ignored, %0d refused as full,",
             n_done + n_ignored + n_full + n_empty, n_done, n_ignored, n_full);
    $display("%0d empty averages; list peaked at %0d of %0d entries.",
             n_empty, peak_len, CAPACITY);
    $display("Saw %0d long output stalls and %0d drain pauses.", holdoffs, drains);
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
